// File: rtl/conv2d_same_zero_pad_top_defines.svh
// Assertion macros shared by the checker of the 2D convolution block.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef CONV2D_SAME_ZERO_PAD_TOP_DEFINES_SVH
`define CONV2D_SAME_ZERO_PAD_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define C2D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c2d check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define C2D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c2d check failed");

`endif

// File: rtl/c2d_pkg.sv
// Package of the 2D convolution block: item types, codes and default sizes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package c2d_pkg;

  localparam int DEF_MAX_ROWS   = 128;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_MAX_HALF_K = 3;

  localparam int OPCODE_W = 2;
  localparam int COORD_W  = 7;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 38;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int SIZE_W   = 8;
  localparam int HALF_W   = 2;
  // Signed tap position: a 7-bit coordinate plus or minus a kernel offset.
  localparam int POS_W    = 10;

  localparam logic [OPCODE_W-1:0] OP_WR_KERNEL = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WR_PIXEL  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPUTE   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NONE      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KHALF_ROWS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KHALF_COLS  = 2'd3;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_OUTSIDE = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    status;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic tap_ok;
  } mac_ctl_t;

endpackage

// File: rtl/c2d_mac.sv
// Shared multiply-accumulate unit of the 2D convolution block.
// Depends on c2d_pkg for widths and the control struct.
`timescale 1ns / 1ps

module c2d_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  c2d_pkg::mac_ctl_t                    ctl,
  input  logic signed [c2d_pkg::DATA_W-1:0]    pix,
  input  logic signed [c2d_pkg::DATA_W-1:0]    coef,
  output logic signed [c2d_pkg::SUM_W-1:0]     acc
);
  import c2d_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_ok;

  // Product register, then accumulate; a tap outside the image adds nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ok <= 1'b0;
    end else begin
      prod_ok <= ctl.tap_ok;
    end
    prod <= pix * coef;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_ok) begin
      acc <= acc + SUM_W'(prod);
    end
  end

endmodule

// File: rtl/conv2d_same_zero_pad_top.sv
// Same-size 2D correlation with zero padding, Q1.15 data, exact Q.30 sums.
// Depends on c2d_pkg and c2d_mac.
`timescale 1ns / 1ps

// User notes. Each input item either writes one kernel coefficient (opcode 0),
// writes one image pixel (opcode 1) or asks for one output position (opcode 2);
// opcode 3 is ignored. Writes produce no result. A compute item walks every
// kernel tap, one tap per cycle, through a single multiply-accumulate unit fed
// by the one read port of the image memory and of the kernel memory. With kernel
// half sizes hr and hc (clamped to MAX_HALF_K), it walks (2*hr+1)*(2*hc+1) taps
// and occupies the block from its acceptance through the tap walk, the drain of
// the read and multiply stages and the load of the result register. The reset
// kernel is 3 by 3; the default MAX_HALF_K allows up to 7 by 7. A compute at a
// position outside the image skips the tap walk and returns status 1 with a zero
// sum. The result register can hold a finished item while write items keep being
// accepted; a compute item waits in its last cycle only if that register is still
// full and stalled. Taps that land outside the image are walked but add nothing,
// which is the same as zero padding. Neither memory is cleared: reading a pixel or
// coefficient that was never written gives an undefined sum. The configuration
// registers should only be written while no compute is in flight.
module conv2d_same_zero_pad_top #(
  parameter int MAX_ROWS   = c2d_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = c2d_pkg::DEF_MAX_COLS,
  parameter int MAX_HALF_K = c2d_pkg::DEF_MAX_HALF_K
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  c2d_pkg::req_t                    req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output c2d_pkg::rsp_t                    rsp,
  input  logic                             cfg_we,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [c2d_pkg::CFG_W-1:0]        cfg_data
);
  import c2d_pkg::*;

  // Memory geometry, all derived from the parameters.
  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KDIM      = 2 * MAX_HALF_K + 1;
  localparam int KER_DEPTH = KDIM * KDIM;
  localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
  localparam int TAP_W     = (KDIM > 1) ? $clog2(KDIM) : 1;
  localparam int HK_W      = (MAX_HALF_K > 0) ? $clog2(MAX_HALF_K + 1) : 1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RUN    = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // Configuration registers.
  logic [SIZE_W-1:0] image_rows;
  logic [SIZE_W-1:0] image_cols;
  logic [HALF_W-1:0] kernel_half_rows;
  logic [HALF_W-1:0] kernel_half_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows       <= SIZE_W'(128);
      image_cols       <= SIZE_W'(128);
      kernel_half_rows <= HALF_W'(1);
      kernel_half_cols <= HALF_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_ROWS: image_rows       <= cfg_data;
        CFG_IMAGE_COLS: image_cols       <= cfg_data;
        CFG_KHALF_ROWS: kernel_half_rows <= cfg_data[HALF_W-1:0];
        CFG_KHALF_COLS: kernel_half_cols <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in effect: registers above the built-in maximum act as the maximum.
  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;
  logic [HK_W-1:0]   half_r_eff;
  logic [HK_W-1:0]   half_c_eff;

  always_comb begin
    rows_eff   = (int'(image_rows) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : image_rows;
    cols_eff   = (int'(image_cols) > MAX_COLS) ? SIZE_W'(MAX_COLS) : image_cols;
    half_r_eff = (int'(kernel_half_rows) > MAX_HALF_K) ? HK_W'(MAX_HALF_K)
                                                       : HK_W'(kernel_half_rows);
    half_c_eff = (int'(kernel_half_cols) > MAX_HALF_K) ? HK_W'(MAX_HALF_K)
                                                       : HK_W'(kernel_half_cols);
  end

  // Sequencer registers.
  logic [1:0]         state;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic [HK_W-1:0]    hr_q;
  logic [HK_W-1:0]    hc_q;
  logic [TAP_W-1:0]   tap_r;
  logic [TAP_W-1:0]   tap_c;
  logic               drain_cnt;
  logic               outside;
  logic               tap_q;

  logic req_fire;
  logic req_inside;
  logic ker_wr_ok;
  logic rsp_free;

  assign req_stall  = (state != S_IDLE);
  assign req_fire   = req_valid && !req_stall;
  assign req_inside = (SIZE_W'(req.row) < rows_eff) && (SIZE_W'(req.col) < cols_eff);
  assign ker_wr_ok  = (int'(req.row) < KDIM) && (int'(req.col) < KDIM);
  assign rsp_free   = !rsp_valid || !rsp_stall;

  // Current tap: image position and bounds check, memory addresses.
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_c;
  logic              tap_in;
  logic              last_c;
  logic              last_r;
  logic [IMG_AW-1:0] img_raddr;
  logic [KER_AW-1:0] ker_raddr;

  always_comb begin
    pos_r  = POS_W'(row_q) + POS_W'(tap_r) - POS_W'(hr_q);
    pos_c  = POS_W'(col_q) + POS_W'(tap_c) - POS_W'(hc_q);
    // A negative position wraps to a large value and fails the upper bound too.
    tap_in = !pos_r[POS_W-1] && !pos_c[POS_W-1] &&
             (pos_r < POS_W'(rows_eff)) && (pos_c < POS_W'(cols_eff));
    last_c = (tap_c == TAP_W'({hc_q, 1'b0}));
    last_r = (tap_r == TAP_W'({hr_q, 1'b0}));
    img_raddr = IMG_AW'(pos_r) * IMG_AW'(MAX_COLS) + IMG_AW'(pos_c);
    ker_raddr = KER_AW'(tap_r) * KER_AW'(KDIM) + KER_AW'(tap_c);
  end

  // Image and kernel memories: one write and one registered read per cycle.
  logic signed [DATA_W-1:0] img_mem [IMG_DEPTH];
  logic signed [DATA_W-1:0] ker_mem [KER_DEPTH];
  logic signed [DATA_W-1:0] pix;
  logic signed [DATA_W-1:0] coef;
  logic                     img_we;
  logic                     ker_we;
  logic [IMG_AW-1:0]        img_waddr;
  logic [KER_AW-1:0]        ker_waddr;

  assign img_we    = req_fire && (req.opcode == OP_WR_PIXEL) && req_inside;
  assign ker_we    = req_fire && (req.opcode == OP_WR_KERNEL) && ker_wr_ok;
  assign img_waddr = IMG_AW'(req.row) * IMG_AW'(MAX_COLS) + IMG_AW'(req.col);
  assign ker_waddr = KER_AW'(req.row) * KER_AW'(KDIM) + KER_AW'(req.col);

  always_ff @(posedge clk) begin
    if (img_we) begin
      img_mem[img_waddr] <= req.value;
    end
    pix <= img_mem[img_raddr];
  end

  always_ff @(posedge clk) begin
    if (ker_we) begin
      ker_mem[ker_waddr] <= req.value;
    end
    coef <= ker_mem[ker_raddr];
  end

  // The tap flag is registered alongside the read data and goes with it into the MAC unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_q <= 1'b0;
    end else begin
      tap_q <= (state == S_RUN) && tap_in;
    end
  end

  mac_ctl_t                mac_ctl;
  logic signed [SUM_W-1:0] acc;

  assign mac_ctl = '{clear: req_fire && (req.opcode == OP_COMPUTE), tap_ok: tap_q};

  c2d_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .pix  (pix),
    .coef (coef),
    .acc  (acc)
  );

  // Sequencer: walk the taps row by row, drain the pipeline, hand off the sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_r     <= '0;
      tap_c     <= '0;
      drain_cnt <= 1'b0;
      outside   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire && (req.opcode == OP_COMPUTE)) begin
            row_q   <= req.row;
            col_q   <= req.col;
            hr_q    <= half_r_eff;
            hc_q    <= half_c_eff;
            tap_r   <= '0;
            tap_c   <= '0;
            outside <= !req_inside;
            state   <= req_inside ? S_RUN : S_FINISH;
          end
        end
        S_RUN: begin
          if (last_c) begin
            tap_c <= '0;
            if (last_r) begin
              drain_cnt <= 1'b1;
              state     <= S_DRAIN;
            end else begin
              tap_r <= tap_r + 1'b1;
            end
          end else begin
            tap_c <= tap_c + 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain_cnt) begin
            drain_cnt <= 1'b0;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register: loaded when the sum is final, held while stalled.
  logic rsp_load;

  assign rsp_load = (state == S_FINISH) && rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.sum    <= outside ? '0 : acc;
      rsp.status <= outside ? ST_OUTSIDE : ST_OK;
    end
  end

endmodule

// File: rtl/c2d_checker.sv
// Port-level checker for the 2D convolution block, bound to its top level.
// Depends on c2d_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "conv2d_same_zero_pad_top_defines.svh"

module c2d_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input c2d_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input c2d_pkg::rsp_t rsp
);
  import c2d_pkg::*;

  // A stalled result item stays put.
  `C2D_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // A position outside the image always reports a zero sum.
  `C2D_ASSERT_IMP(a_outside_zero, rsp_valid && (rsp.status == ST_OUTSIDE), rsp.sum == '0)

  // A compute item keeps the block busy for at least the next cycle.
  `C2D_ASSERT_NXT(a_compute_busy,
                  req_valid && !req_stall && (req.opcode == OP_COMPUTE), req_stall)

  // A new result item only appears at the end of a busy stretch.
  `C2D_ASSERT_IMP(a_rsp_after_busy, $rose(rsp_valid), $past(req_stall))

endmodule

bind conv2d_same_zero_pad_top c2d_checker u_c2d_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
